/* rtl/dra_pkg.sv */
`default_nettype none

package dra_pkg;

   localparam int CoordWidth  = 12;
   localparam int SizeWidth   = 13;
   localparam int RectWidth   = 16;
   localparam int SpanWidth   = RectWidth + 2;
   localparam logic [SizeWidth-1:0] MaxScreen = 13'd4096;

   localparam logic [SizeWidth-1:0] ResetScreenWidth  = 13'd320;
   localparam logic [SizeWidth-1:0] ResetScreenHeight = 13'd240;

   typedef enum logic {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_MARK = 1'b0,
      ACT_TAKE = 1'b1
   } action_type;

   // One classified item as it passes from the front to the back.
   typedef struct packed {
      action_type            action;
      logic                  valid;
      logic [CoordWidth-1:0] x1;
      logic [CoordWidth-1:0] x2;
      logic [CoordWidth-1:0] y1;
      logic [CoordWidth-1:0] y2;
   } dec_type;

   // Status of the queue between the front and the back.
   typedef struct packed {
      logic empty;
   } dec_ctrl_type;

   typedef struct packed {
      logic                  box_valid;
      logic [CoordWidth-1:0] box_x;
      logic [CoordWidth-1:0] box_y;
      logic [SizeWidth-1:0]  box_width;
      logic [SizeWidth-1:0]  box_height;
   } rsp_type;

   function automatic logic [SizeWidth-1:0] eff_size(input logic [SizeWidth-1:0] reg_value);
      eff_size = (reg_value > MaxScreen) ? MaxScreen : reg_value;
   endfunction

endpackage

`default_nettype wire

/* rtl/dirty_region_accumulator.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_push / req_full  action, rect_x, rect_y, rect_width, rect_height
// rsp       out        rsp_pop / rsp_empty  box_valid, box_x, box_y, box_width, box_height
// csr       in         csr_wr_en            csr_index, csr_wr_data
//
// One item is taken every cycle while req_full is low; it waits in the front queue until the back
// moves its result into the result queue, from which it can be taken.
// The front clips each rectangle as it is pushed, and the back merges it into the held box
// as it is popped; a two-item queue sits between them and another holds the results.
// Reset is synchronous and clears the box and both queues; the screen size returns to 320x240.
// A stalled result side fills both queues, after which req_full rises.
`default_nettype none

module dirty_region_accumulator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic                                 req_action,
   input  wire logic signed [dra_pkg::RectWidth-1:0] req_rect_x,
   input  wire logic signed [dra_pkg::RectWidth-1:0] req_rect_y,
   input  wire logic signed [dra_pkg::RectWidth-1:0] req_rect_width,
   input  wire logic signed [dra_pkg::RectWidth-1:0] req_rect_height,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic                                      rsp_box_valid,
   output logic [dra_pkg::CoordWidth-1:0]            rsp_box_x,
   output logic [dra_pkg::CoordWidth-1:0]            rsp_box_y,
   output logic [dra_pkg::SizeWidth-1:0]             rsp_box_width,
   output logic [dra_pkg::SizeWidth-1:0]             rsp_box_height,
   input  wire logic                                 csr_wr_en,
   input  wire logic                                 csr_index,
   input  wire logic [dra_pkg::SizeWidth-1:0]        csr_wr_data
);

   logic [dra_pkg::SizeWidth-1:0] screen_width_ff, screen_width_in;
   logic [dra_pkg::SizeWidth-1:0] screen_height_ff, screen_height_in;
   logic [dra_pkg::SizeWidth-1:0] screen_w, screen_h;

   dra_pkg::dec_ctrl_type dec_status;
   dra_pkg::dec_type      dec_entry;
   logic                  dec_pop;

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_wr_en) begin
         unique case (dra_pkg::csr_index_type'(csr_index))
            dra_pkg::CSR_SCREEN_WIDTH:  screen_width_in  = csr_wr_data;
            dra_pkg::CSR_SCREEN_HEIGHT: screen_height_in = csr_wr_data;
            default:                    screen_width_in  = screen_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= dra_pkg::ResetScreenWidth;
         screen_height_ff <= dra_pkg::ResetScreenHeight;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   assign screen_w = dra_pkg::eff_size(screen_width_ff);
   assign screen_h = dra_pkg::eff_size(screen_height_ff);

   dra_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_action      (req_action),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .screen_w        (screen_w),
      .screen_h        (screen_h),
      .dec_pop         (dec_pop),
      .dec_status      (dec_status),
      .dec_entry       (dec_entry)
   );

   dra_back u_back (
      .clock          (clock),
      .reset          (reset),
      .dec_status     (dec_status),
      .dec_entry      (dec_entry),
      .dec_pop        (dec_pop),
      .screen_w       (screen_w),
      .screen_h       (screen_h),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_box_valid  (rsp_box_valid),
      .rsp_box_x      (rsp_box_x),
      .rsp_box_y      (rsp_box_y),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height)
   );

endmodule

`default_nettype wire

/* rtl/dra_front.sv */
`default_nettype none

module dra_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic                              req_action,
   input  wire logic signed [dra_pkg::RectWidth-1:0] req_rect_x,
   input  wire logic signed [dra_pkg::RectWidth-1:0] req_rect_y,
   input  wire logic signed [dra_pkg::RectWidth-1:0] req_rect_width,
   input  wire logic signed [dra_pkg::RectWidth-1:0] req_rect_height,
   input  wire logic [dra_pkg::SizeWidth-1:0]     screen_w,
   input  wire logic [dra_pkg::SizeWidth-1:0]     screen_h,
   input  wire logic                              dec_pop,
   output dra_pkg::dec_ctrl_type                  dec_status,
   output dra_pkg::dec_type                       dec_entry
);

   dra_pkg::dec_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   dra_pkg::dec_type new_entry;
   logic             x_ok, y_ok;
   logic [dra_pkg::CoordWidth-1:0] x1, x2, y1, y2;
   logic             do_push, do_pop;

   // Clips one span [lo, lo+len-1] to [0, lim-1].
   function automatic logic clip_span(
      input  logic signed [dra_pkg::RectWidth-1:0] lo,
      input  logic signed [dra_pkg::RectWidth-1:0] len,
      input  logic [dra_pkg::SizeWidth-1:0]        lim,
      output logic [dra_pkg::CoordWidth-1:0]       a,
      output logic [dra_pkg::CoordWidth-1:0]       b
   );
      logic signed [dra_pkg::SpanWidth-1:0] lo_s;
      logic signed [dra_pkg::SpanWidth-1:0] hi_s;
      logic signed [dra_pkg::SpanWidth-1:0] lim_s;
      logic [dra_pkg::SizeWidth-1:0]        lim_m1;
      lo_s   = dra_pkg::SpanWidth'(lo);
      hi_s   = lo_s + dra_pkg::SpanWidth'(len) - dra_pkg::SpanWidth'(1);
      lim_s  = dra_pkg::SpanWidth'(signed'({1'b0, lim}));
      lim_m1 = lim - dra_pkg::SizeWidth'(1);
      clip_span = (len > 0) && (lim != '0) && (hi_s >= 0) && (lo_s < lim_s);
      a = (lo_s < 0) ? '0 : lo_s[dra_pkg::CoordWidth-1:0];
      b = (hi_s >= lim_s) ? lim_m1[dra_pkg::CoordWidth-1:0] : hi_s[dra_pkg::CoordWidth-1:0];
   endfunction

   always_comb begin
      x_ok = clip_span(req_rect_x, req_rect_width, screen_w, x1, x2);
      y_ok = clip_span(req_rect_y, req_rect_height, screen_h, y1, y2);
      new_entry.action = dra_pkg::action_type'(req_action);
      new_entry.valid  = x_ok && y_ok;
      new_entry.x1     = x1;
      new_entry.x2     = x2;
      new_entry.y1     = y1;
      new_entry.y2     = y2;
   end

   assign req_full         = (count_ff == 2'd2);
   assign do_push          = req_push && !req_full;
   assign do_pop           = dec_pop && (count_ff != 2'd0);
   assign dec_status.empty = (count_ff == 2'd0);
   assign dec_entry        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/dra_back.sv */
`default_nettype none

module dra_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dra_pkg::dec_ctrl_type         dec_status,
   input  wire dra_pkg::dec_type              dec_entry,
   output logic                               dec_pop,
   input  wire logic [dra_pkg::SizeWidth-1:0] screen_w,
   input  wire logic [dra_pkg::SizeWidth-1:0] screen_h,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic                               rsp_box_valid,
   output logic [dra_pkg::CoordWidth-1:0]     rsp_box_x,
   output logic [dra_pkg::CoordWidth-1:0]     rsp_box_y,
   output logic [dra_pkg::SizeWidth-1:0]      rsp_box_width,
   output logic [dra_pkg::SizeWidth-1:0]      rsp_box_height
);

   localparam int CW = dra_pkg::CoordWidth;
   localparam int SW = dra_pkg::SizeWidth;

   // The box is held as inclusive edges; sizes are formed only for results.
   logic          held_ff, held_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] right_ff, right_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] bottom_ff, bottom_in;

   dra_pkg::rsp_type res_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   dra_pkg::rsp_type new_res;
   dra_pkg::rsp_type head;
   logic [CW-1:0]    ml, mr, mt, mb;
   logic             do_work, do_pop;

   assign do_work = !dec_status.empty && (count_ff != 2'd2);
   assign dec_pop = do_work;
   assign do_pop  = rsp_pop && (count_ff != 2'd0);

   always_comb begin
      ml = (held_ff && left_ff < dec_entry.x1) ? left_ff : dec_entry.x1;
      mt = (held_ff && top_ff < dec_entry.y1) ? top_ff : dec_entry.y1;
      mr = (held_ff && right_ff > dec_entry.x2) ? right_ff : dec_entry.x2;
      mb = (held_ff && bottom_ff > dec_entry.y2) ? bottom_ff : dec_entry.y2;

      held_in   = held_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;

      new_res.box_valid  = held_ff;
      new_res.box_x      = left_ff;
      new_res.box_y      = top_ff;
      new_res.box_width  = {1'b0, right_ff} - {1'b0, left_ff} + SW'(1);
      new_res.box_height = {1'b0, bottom_ff} - {1'b0, top_ff} + SW'(1);

      unique case (dec_entry.action)
         dra_pkg::ACT_TAKE: begin
            if (!held_ff) begin
               new_res.box_x      = '0;
               new_res.box_y      = '0;
               new_res.box_width  = screen_w;
               new_res.box_height = screen_h;
            end
            held_in   = 1'b0;
            left_in   = '0;
            right_in  = '0;
            top_in    = '0;
            bottom_in = '0;
         end
         dra_pkg::ACT_MARK: begin
            if (dec_entry.valid) begin
               held_in            = 1'b1;
               left_in            = ml;
               right_in           = mr;
               top_in             = mt;
               bottom_in          = mb;
               new_res.box_valid  = 1'b1;
               new_res.box_x      = ml;
               new_res.box_y      = mt;
               new_res.box_width  = {1'b0, mr} - {1'b0, ml} + SW'(1);
               new_res.box_height = {1'b0, mb} - {1'b0, mt} + SW'(1);
            end else begin
               // A rejected mark reports the box unchanged but not valid, or all zero if none.
               new_res.box_valid = 1'b0;
               if (!held_ff) begin
                  new_res.box_width  = '0;
                  new_res.box_height = '0;
               end
            end
         end
         default: begin
            held_in = held_ff;
         end
      endcase

      wr_ptr_in = wr_ptr_ff ^ do_work;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_work} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         left_ff   <= '0;
         right_ff  <= '0;
         top_ff    <= '0;
         bottom_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_work) begin
            held_ff   <= held_in;
            left_ff   <= left_in;
            right_ff  <= right_in;
            top_ff    <= top_in;
            bottom_ff <= bottom_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_work) begin
         res_ff[wr_ptr_ff] <= new_res;
      end
   end

   assign head           = res_ff[rd_ptr_ff];
   assign rsp_empty      = (count_ff == 2'd0);
   assign rsp_box_valid  = head.box_valid;
   assign rsp_box_x      = head.box_x;
   assign rsp_box_y      = head.box_y;
   assign rsp_box_width  = head.box_width;
   assign rsp_box_height = head.box_height;

endmodule

`default_nettype wire

/* rtl/dra_checker.sv */
`default_nettype none

module dra_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_full,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic                           rsp_box_valid,
   input wire logic [dra_pkg::CoordWidth-1:0] rsp_box_x,
   input wire logic [dra_pkg::CoordWidth-1:0] rsp_box_y,
   input wire logic [dra_pkg::SizeWidth-1:0]  rsp_box_width,
   input wire logic [dra_pkg::SizeWidth-1:0]  rsp_box_height
);

   // A waiting result that is not taken stays as it is.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_box_valid)
         && $stable(rsp_box_x) && $stable(rsp_box_y)
         && $stable(rsp_box_width) && $stable(rsp_box_height)))
      else $error("result changed while stalled");

   // The result queue is empty and the request queue is not full once reset has been applied.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // A held box always covers at least one pixel.
   a_box_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_box_valid) |-> (rsp_box_width != '0 && rsp_box_height != '0))
      else $error("valid box has no area");

   // No box reaches beyond the largest screen.
   a_box_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_box_width <= dra_pkg::MaxScreen
         && rsp_box_height <= dra_pkg::MaxScreen))
      else $error("box larger than any screen");

endmodule

bind dirty_region_accumulator dra_checker u_dra_checker (.*);

`default_nettype wire
